// ===== hdl/rpd_pkg.sv =====
package rpd_pkg;

   // fixed field widths of the channels and the csr port
   localparam int CHAN_BITS    = 3;
   localparam int STAMP_BITS   = 32;
   localparam int POS_BITS     = 8;
   localparam int PW_BITS      = 11;
   localparam int OFS_BITS     = 10;
   localparam int CSR_BITS     = 8;
   localparam int CSR_IDX_BITS = 3;

   typedef logic [CSR_IDX_BITS-1:0] csr_index_type;

   // register map
   localparam csr_index_type CSR_DEADBAND    = 3'd0;
   localparam csr_index_type CSR_SNAP_TOL    = 3'd1;
   localparam csr_index_type CSR_SNAP_MASK   = 3'd2;
   localparam csr_index_type CSR_NOTIFY_MASK = 3'd3;

   // register reset values
   localparam logic [CSR_BITS-1:0] DEADBAND_RST    = 8'd10;
   localparam logic [CSR_BITS-1:0] SNAP_TOL_RST    = 8'd20;
   localparam logic [CSR_BITS-1:0] SNAP_MASK_RST   = 8'd80;
   localparam logic [CSR_BITS-1:0] NOTIFY_MASK_RST = 8'd0;

   // edge kinds
   localparam logic EDGE_RISE = 1'b0;
   localparam logic EDGE_FALL = 1'b1;

   // servo pulse points in microseconds
   localparam logic [PW_BITS-1:0] PW_LOW  = 11'd1000;
   localparam logic [PW_BITS-1:0] PW_MID  = 11'd1500;
   localparam logic [PW_BITS-1:0] PW_HIGH = 11'd2000;

   // x * 255 / 1000 == (x * 16712) >> 16 for every x in 0..1000
   localparam int RECIP_BITS = 15;
   localparam logic [RECIP_BITS-1:0] POS_RECIP = 15'd16712;
   localparam int POS_SHIFT  = 16;
   localparam int PROD_BITS  = OFS_BITS + RECIP_BITS;

   typedef struct packed {
      logic                 emit;
      logic [CHAN_BITS-1:0] out_channel;
      logic [PW_BITS-1:0]   width_us;
   } result_type;

endpackage

// ===== hdl/rpd_if.sv =====
interface rpd_req_if;
   import rpd_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CHAN_BITS-1:0]  channel;
   logic                  mode;
   logic [STAMP_BITS-1:0] time_us;

   modport source (output valid, output channel, output mode, output time_us, input ready);
   modport sink (input valid, input channel, input mode, input time_us, output ready);
endinterface

interface rpd_rsp_if;
   import rpd_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [CHAN_BITS-1:0] out_channel;
   logic [POS_BITS-1:0]  position;
   logic [PW_BITS-1:0]   width_us;

   modport source (output valid, output out_channel, output position, output width_us,
                   input ready);
   modport sink (input valid, input out_channel, input position, input width_us,
                 output ready);
endinterface

// ===== hdl/rc_pwm_channel_decoder.sv =====
// rc_pwm_channel_decoder takes one edge event per beat (channel, rising or falling,
// microsecond timestamp) and reports a servo channel's clamped pulse width and its
// 0..255 position whenever that value changes on a channel enabled in notify_mask.
// Throughput is one event per clock, back to back, including repeated events on the
// same channel: the per-channel start time and held width live in two small memories
// with a registered read, and a write landing in the read cycle is forwarded. A result
// beat is offered after the memory read at the accepting edge, the registered width
// update and the registered position scaling, and then waits on rsp_port.ready. Events
// that emit nothing flow past a waiting beat until one that emits is held behind it;
// one more event of any kind then waits in stage 1 and req_port.ready drops. State
// reads as zero after reset via a valid flag per channel per memory, no clearing pass.
// Csr writes are meant for idle periods only; indexes beyond the map are ignored.
module rc_pwm_channel_decoder #(
   parameter int CHANNELS   = 8,
   parameter int TIME_BITS  = 32,
   parameter int WIDTH_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   rpd_req_if.sink                          req_port,
   rpd_rsp_if.source                        rsp_port,
   input  logic                             csr_we,
   input  rpd_pkg::csr_index_type           csr_index,
   input  logic [rpd_pkg::CSR_BITS-1:0]     csr_wdata
);
   import rpd_pkg::*;

   localparam int IDX_BITS = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int EXT_BITS = IDX_BITS + CHAN_BITS;

   // configuration registers
   logic [CSR_BITS-1:0] deadband_ff;
   logic [CSR_BITS-1:0] snap_tol_ff;
   logic [CSR_BITS-1:0] snap_mask_ff;
   logic [CSR_BITS-1:0] notify_mask_ff;

   // stage 1: event waiting on its memory read
   logic                 s1_vld_ff;
   logic [CHAN_BITS-1:0] s1_ch_ff;
   logic                 s1_mode_ff;
   logic                 s1_inrange_ff;
   logic [TIME_BITS-1:0] s1_time_ff;

   logic                  accept;
   logic                  req_inrange;
   logic [EXT_BITS-1:0]   req_ch_ext;
   logic [EXT_BITS-1:0]   s1_ch_ext;
   logic                  s2_ready;
   logic                  s1_active;
   logic [TIME_BITS-1:0]  start_rdata;
   logic [WIDTH_BITS-1:0] held_rdata;
   logic                  start_we;
   logic                  held_we;
   logic [WIDTH_BITS-1:0] held_wdata;
   result_type            res;

   always_ff @(posedge clock) begin
      if (reset) begin
         deadband_ff    <= DEADBAND_RST;
         snap_tol_ff    <= SNAP_TOL_RST;
         snap_mask_ff   <= SNAP_MASK_RST;
         notify_mask_ff <= NOTIFY_MASK_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_DEADBAND:    deadband_ff    <= csr_wdata;
            CSR_SNAP_TOL:    snap_tol_ff    <= csr_wdata;
            CSR_SNAP_MASK:   snap_mask_ff   <= csr_wdata;
            CSR_NOTIFY_MASK: notify_mask_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // stage 1 frees up when its event moves on; events that emit nothing still pass
   assign req_port.ready = !s1_vld_ff || s2_ready;
   assign accept         = req_port.valid && req_port.ready;
   assign req_ch_ext     = EXT_BITS'(req_port.channel);
   assign req_inrange    = req_ch_ext < EXT_BITS'(CHANNELS);
   assign s1_ch_ext      = EXT_BITS'(s1_ch_ff);
   assign s1_active      = s1_vld_ff && s1_inrange_ff && s2_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (req_port.ready) begin
         s1_vld_ff <= req_port.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ch_ff      <= req_port.channel;
         s1_mode_ff    <= req_port.mode;
         s1_inrange_ff <= req_inrange;
         s1_time_ff    <= TIME_BITS'(req_port.time_us);
      end
   end

   // per-channel state, read at accept, written back when stage 1 retires
   rpd_chan_mem #(
      .CHANNELS   (CHANNELS),
      .TIME_BITS  (TIME_BITS),
      .WIDTH_BITS (WIDTH_BITS),
      .IDX_BITS   (IDX_BITS)
   ) u_mem (
      .clock       (clock),
      .reset       (reset),
      .rd_en       (accept && req_inrange),
      .rd_idx      (req_ch_ext[IDX_BITS-1:0]),
      .wr_idx      (s1_ch_ext[IDX_BITS-1:0]),
      .start_we    (start_we),
      .start_wdata (s1_time_ff),
      .held_we     (held_we),
      .held_wdata  (held_wdata),
      .start_rdata (start_rdata),
      .held_rdata  (held_rdata)
   );

   // width measurement, deadband, snapping and change test
   rpd_pulse_calc #(
      .TIME_BITS  (TIME_BITS),
      .WIDTH_BITS (WIDTH_BITS)
   ) u_calc (
      .active     (s1_active),
      .mode       (s1_mode_ff),
      .channel    (s1_ch_ff),
      .time_val   (s1_time_ff),
      .start      (start_rdata),
      .held       (held_rdata),
      .deadband   (deadband_ff),
      .snap_tol   (snap_tol_ff),
      .snap_en    (snap_mask_ff[s1_ch_ff]),
      .notify_en  (notify_mask_ff[s1_ch_ff]),
      .start_we   (start_we),
      .held_we    (held_we),
      .held_wdata (held_wdata),
      .res        (res)
   );

   // position scaling and the result register
   rpd_scale_out u_out (
      .clock    (clock),
      .reset    (reset),
      .in_valid (s1_vld_ff),
      .in_ready (s2_ready),
      .res      (res),
      .rsp_port (rsp_port)
   );
endmodule

// ===== hdl/rpd_chan_mem.sv =====
module rpd_chan_mem #(
   parameter int CHANNELS   = 8,
   parameter int TIME_BITS  = 32,
   parameter int WIDTH_BITS = 16,
   parameter int IDX_BITS   = 3
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  rd_en,
   input  logic [IDX_BITS-1:0]   rd_idx,
   input  logic [IDX_BITS-1:0]   wr_idx,
   input  logic                  start_we,
   input  logic [TIME_BITS-1:0]  start_wdata,
   input  logic                  held_we,
   input  logic [WIDTH_BITS-1:0] held_wdata,
   output logic [TIME_BITS-1:0]  start_rdata,
   output logic [WIDTH_BITS-1:0] held_rdata
);
   logic [TIME_BITS-1:0]  start_mem_ff [CHANNELS];
   logic [WIDTH_BITS-1:0] held_mem_ff  [CHANNELS];
   logic [TIME_BITS-1:0]  start_q_ff;
   logic [WIDTH_BITS-1:0] held_q_ff;
   logic [CHANNELS-1:0]   start_vld_ff;
   logic [CHANNELS-1:0]   held_vld_ff;
   logic                  start_ok_ff;
   logic                  held_ok_ff;
   logic                  start_fwd_ff;
   logic                  held_fwd_ff;
   logic [TIME_BITS-1:0]  start_fwd_data_ff;
   logic [WIDTH_BITS-1:0] held_fwd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (start_we) begin
         start_mem_ff[wr_idx] <= start_wdata;
      end
      if (held_we) begin
         held_mem_ff[wr_idx] <= held_wdata;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         start_q_ff <= start_mem_ff[rd_idx];
         held_q_ff  <= held_mem_ff[rd_idx];
      end
   end

   // entries never written read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         start_vld_ff <= '0;
         held_vld_ff  <= '0;
         start_ok_ff  <= 1'b0;
         held_ok_ff   <= 1'b0;
         start_fwd_ff <= 1'b0;
         held_fwd_ff  <= 1'b0;
      end else begin
         if (start_we) begin
            start_vld_ff[wr_idx] <= 1'b1;
         end
         if (held_we) begin
            held_vld_ff[wr_idx] <= 1'b1;
         end
         if (rd_en) begin
            start_ok_ff  <= start_vld_ff[rd_idx];
            held_ok_ff   <= held_vld_ff[rd_idx];
            start_fwd_ff <= start_we && (wr_idx == rd_idx);
            held_fwd_ff  <= held_we && (wr_idx == rd_idx);
         end
      end
   end

   // write landing in the same cycle as the read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         start_fwd_data_ff <= start_wdata;
         held_fwd_data_ff  <= held_wdata;
      end
   end

   always_comb begin
      if (start_fwd_ff) begin
         start_rdata = start_fwd_data_ff;
      end else if (start_ok_ff) begin
         start_rdata = start_q_ff;
      end else begin
         start_rdata = '0;
      end
      if (held_fwd_ff) begin
         held_rdata = held_fwd_data_ff;
      end else if (held_ok_ff) begin
         held_rdata = held_q_ff;
      end else begin
         held_rdata = '0;
      end
   end
endmodule

// ===== hdl/rpd_pulse_calc.sv =====
module rpd_pulse_calc #(
   parameter int TIME_BITS  = 32,
   parameter int WIDTH_BITS = 16
) (
   input  logic                          active,
   input  logic                          mode,
   input  logic [rpd_pkg::CHAN_BITS-1:0] channel,
   input  logic [TIME_BITS-1:0]          time_val,
   input  logic [TIME_BITS-1:0]          start,
   input  logic [WIDTH_BITS-1:0]         held,
   input  logic [rpd_pkg::CSR_BITS-1:0]  deadband,
   input  logic [rpd_pkg::CSR_BITS-1:0]  snap_tol,
   input  logic                          snap_en,
   input  logic                          notify_en,
   output logic                          start_we,
   output logic                          held_we,
   output logic [WIDTH_BITS-1:0]         held_wdata,
   output rpd_pkg::result_type           res
);
   import rpd_pkg::*;

   localparam int EW = WIDTH_BITS + 1;

   logic [TIME_BITS-1:0]  diff;
   logic [WIDTH_BITS-1:0] meas;
   logic [EW-1:0]         meas_e;
   logic [EW-1:0]         last_e;
   logic [EW-1:0]         db_e;
   logic [EW-1:0]         tol_e;
   logic                  outside;
   logic [WIDTH_BITS-1:0] held_upd;
   logic [WIDTH_BITS-1:0] snapped;
   logic [WIDTH_BITS-1:0] work;
   logic [PW_BITS-1:0]    clamped;

   function automatic logic near(input logic [EW-1:0] v, input logic [EW-1:0] p,
                                 input logic [EW-1:0] tol);
      return (v + tol >= p) && (v <= p + tol);
   endfunction

   assign diff = time_val - start;

   // saturate the wrapped difference to the width store
   generate
      if (TIME_BITS > WIDTH_BITS) begin : g_sat
         assign meas = (|diff[TIME_BITS-1:WIDTH_BITS]) ? '1 : diff[WIDTH_BITS-1:0];
      end else begin : g_nosat
         assign meas = WIDTH_BITS'(diff);
      end
   endgenerate

   assign meas_e  = EW'(meas);
   assign last_e  = EW'(held);
   assign db_e    = EW'(deadband);
   assign tol_e   = EW'(snap_tol);
   assign outside = (meas_e + db_e < last_e) || (meas_e > last_e + db_e);
   assign held_upd = outside ? meas : held;

   // lower snap points take priority when windows overlap
   always_comb begin
      priority if (near(EW'(held_upd), EW'(PW_LOW), tol_e)) begin
         snapped = WIDTH_BITS'(PW_LOW);
      end else if (near(EW'(held_upd), EW'(PW_MID), tol_e)) begin
         snapped = WIDTH_BITS'(PW_MID);
      end else if (near(EW'(held_upd), EW'(PW_HIGH), tol_e)) begin
         snapped = WIDTH_BITS'(PW_HIGH);
      end else begin
         snapped = held_upd;
      end
   end

   assign held_wdata = snap_en ? snapped : held_upd;
   assign work       = snap_en ? snapped : meas;

   always_comb begin
      priority if (work < WIDTH_BITS'(PW_LOW)) begin
         clamped = PW_LOW;
      end else if (work > WIDTH_BITS'(PW_HIGH)) begin
         clamped = PW_HIGH;
      end else begin
         clamped = work[PW_BITS-1:0];
      end
   end

   assign start_we = active && (mode == EDGE_RISE);
   assign held_we  = active && (mode == EDGE_FALL);

   // change test uses the unclamped previous width
   assign res.emit        = held_we && notify_en && (WIDTH_BITS'(clamped) != held);
   assign res.out_channel = channel;
   assign res.width_us    = clamped;
endmodule

// ===== hdl/rpd_scale_out.sv =====
module rpd_scale_out (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  rpd_pkg::result_type res,
   rpd_rsp_if.source           rsp_port
);
   import rpd_pkg::*;

   logic                 s2_vld_ff;
   logic [CHAN_BITS-1:0] s2_ch_ff;
   logic [PW_BITS-1:0]   s2_w_ff;
   logic [OFS_BITS-1:0]  s2_ofs_ff;
   logic                 out_vld_ff;
   logic [CHAN_BITS-1:0] out_ch_ff;
   logic [PW_BITS-1:0]   out_w_ff;
   logic [POS_BITS-1:0]  out_pos_ff;
   logic                 out_free;
   logic [PROD_BITS-1:0] prod;
   logic [PW_BITS-1:0]   ofs_full;

   assign out_free = !out_vld_ff || rsp_port.ready;
   assign in_ready = !s2_vld_ff || out_free;
   assign ofs_full = res.width_us - PW_LOW;
   assign prod     = PROD_BITS'(s2_ofs_ff) * PROD_BITS'(POS_RECIP);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         if (in_ready) begin
            s2_vld_ff <= in_valid && res.emit;
         end
         if (out_free) begin
            out_vld_ff <= s2_vld_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid && res.emit) begin
         s2_ch_ff  <= res.out_channel;
         s2_w_ff   <= res.width_us;
         s2_ofs_ff <= ofs_full[OFS_BITS-1:0];
      end
      if (out_free && s2_vld_ff) begin
         out_ch_ff  <= s2_ch_ff;
         out_w_ff   <= s2_w_ff;
         out_pos_ff <= prod[POS_SHIFT +: POS_BITS];
      end
   end

   assign rsp_port.valid       = out_vld_ff;
   assign rsp_port.out_channel = out_ch_ff;
   assign rsp_port.position    = out_pos_ff;
   assign rsp_port.width_us    = out_w_ff;
endmodule

// ===== sim/rpd_checker.sv =====
`timescale 1ns / 100ps

module rpd_checker (
   input  logic                         clock,
   input  logic                         reset,
   rpd_req_if                           req_mon,
   rpd_rsp_if                           rsp_mon,
   input  logic                         csr_we,
   input  rpd_pkg::csr_index_type       csr_index,
   input  logic [rpd_pkg::CSR_BITS-1:0] csr_wdata,
   output int                           failures,
   output int                           pending,
   output int                           results_seen
);
   import rpd_pkg::*;

   localparam int MAX_SHOWN = 20;
   localparam int PW_SAT    = 65535;

   typedef struct {
      logic [CHAN_BITS-1:0] channel;
      logic [POS_BITS-1:0]  position;
      logic [PW_BITS-1:0]   width;
   } servo_update_type;

   logic [STAMP_BITS-1:0] rise_stamp [8];
   logic [15:0]           held_pw [8];
   logic [15:0]           last_pw [8];
   logic [CSR_BITS-1:0]   deadband;
   logic [CSR_BITS-1:0]   snap_tol;
   logic [CSR_BITS-1:0]   snap_mask;
   logic [CSR_BITS-1:0]   notify_mask;
   servo_update_type      update_q [$];
   servo_update_type      due;

   task automatic report_mismatch(input string what);
      failures++;
      if (failures <= MAX_SHOWN)
         $display("%0t mismatch: %s", $realtime, what);
   endtask

   function automatic bit near_pulse(input int unsigned v, input int unsigned p);
      return (v + snap_tol >= p) && (v <= p + snap_tol);
   endfunction

   // 1000 wins over 1500, which wins over 2000, when windows overlap
   function automatic logic [15:0] snap_pulse(input logic [15:0] v);
      if (near_pulse(v, PW_LOW))
         return 16'(PW_LOW);
      if (near_pulse(v, PW_MID))
         return 16'(PW_MID);
      if (near_pulse(v, PW_HIGH))
         return 16'(PW_HIGH);
      return v;
   endfunction

   task automatic predict_edge(input logic [CHAN_BITS-1:0] ch, input logic mode,
                               input logic [STAMP_BITS-1:0] stamp);
      logic [STAMP_BITS-1:0] span;
      int unsigned           pw;
      int unsigned           prev;
      servo_update_type      upd;
      if (mode == EDGE_RISE) begin
         rise_stamp[ch] = stamp;
      end else begin
         span = stamp - rise_stamp[ch];
         pw   = (span > PW_SAT) ? PW_SAT : span;
         prev = last_pw[ch];
         if (pw + deadband < prev || pw > prev + deadband)
            held_pw[ch] = 16'(pw);
         if (snap_mask[ch]) begin
            held_pw[ch] = snap_pulse(held_pw[ch]);
            pw          = held_pw[ch];
         end
         if (pw < PW_LOW)
            pw = PW_LOW;
         else if (pw > PW_HIGH)
            pw = PW_HIGH;
         // clamped width against the raw last width
         if (pw != prev && notify_mask[ch]) begin
            upd.channel  = ch;
            upd.position = POS_BITS'((pw - PW_LOW) * 255 / 1000);
            upd.width    = PW_BITS'(pw);
            update_q.push_back(upd);
         end
         last_pw[ch] = held_pw[ch];
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         foreach (rise_stamp[c]) begin
            rise_stamp[c] = '0;
            held_pw[c]    = '0;
            last_pw[c]    = '0;
         end
         deadband     = DEADBAND_RST;
         snap_tol     = SNAP_TOL_RST;
         snap_mask    = SNAP_MASK_RST;
         notify_mask  = NOTIFY_MASK_RST;
         update_q.delete();
         failures     = 0;
         results_seen = 0;
         pending      = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_DEADBAND:    deadband    = csr_wdata;
               CSR_SNAP_TOL:    snap_tol    = csr_wdata;
               CSR_SNAP_MASK:   snap_mask   = csr_wdata;
               CSR_NOTIFY_MASK: notify_mask = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (update_q.size() == 0) begin
               report_mismatch($sformatf("unexpected beat ch %0d width %0d",
                                         rsp_mon.out_channel, rsp_mon.width_us));
            end else begin
               due = update_q.pop_front();
               results_seen++;
               if (rsp_mon.out_channel !== due.channel)
                  report_mismatch($sformatf("out_channel %0d, want %0d",
                                            rsp_mon.out_channel, due.channel));
               if (rsp_mon.position !== due.position)
                  report_mismatch($sformatf("ch %0d position %0d, want %0d", due.channel,
                                            rsp_mon.position, due.position));
               if (rsp_mon.width_us !== due.width)
                  report_mismatch($sformatf("ch %0d width_us %0d, want %0d", due.channel,
                                            rsp_mon.width_us, due.width));
            end
         end
         if (req_mon.valid && req_mon.ready)
            predict_edge(req_mon.channel, req_mon.mode, req_mon.time_us);
         pending = update_q.size();
      end
   end

endmodule

// ===== sim/rc_pwm_channel_decoder_test.sv =====
`timescale 1ns / 100ps

module rc_pwm_channel_decoder_test;
   import rpd_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int RANDOM_ITEMS  = 1300;
   localparam int PHASES        = 6;
   localparam int SETTLE_CYCLES = 8;

   logic                clock;
   logic                reset;
   logic                csr_we;
   csr_index_type       csr_index;
   logic [CSR_BITS-1:0] csr_wdata;

   rpd_req_if req_bus ();
   rpd_rsp_if rsp_bus ();

   int  failures;
   int  pending;
   int  results_seen;
   int  cycles = 0;
   int  beats_sent = 0;
   bit  quiet = 1'b0;

   // rough per-channel memory of what the stimulus sent, to aim near it
   logic [15:0]           recent_pw [8];
   logic [STAMP_BITS-1:0] recent_rise [8];

   rc_pwm_channel_decoder dut (
      .clock     (clock),
      .reset     (reset),
      .req_port  (req_bus),
      .rsp_port  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   rpd_checker pulse_check (
      .clock        (clock),
      .reset        (reset),
      .req_mon      (req_bus),
      .rsp_mon      (rsp_bus),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .failures     (failures),
      .pending      (pending),
      .results_seen (results_seen)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // hard stop if the block hangs
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // result side backpressure, off during the quiet stretch
   always @(posedge clock) begin
      if (reset)
         rsp_bus.ready <= 1'b0;
      else
         rsp_bus.ready <= quiet || ($urandom_range(0, 99) >= 26);
   end

   // one edge beat; valid stays high into the next beat unless we idle first
   task automatic send_edge(input logic [CHAN_BITS-1:0] ch, input logic mode,
                            input logic [STAMP_BITS-1:0] stamp);
      while (!quiet && $urandom_range(0, 99) < 26) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.channel <= ch;
      req_bus.mode    <= mode;
      req_bus.time_us <= stamp;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      beats_sent++;
   endtask

   task automatic send_pulse(input logic [CHAN_BITS-1:0] ch,
                             input logic [STAMP_BITS-1:0] start,
                             input logic [STAMP_BITS-1:0] width);
      send_edge(ch, EDGE_RISE, start);
      send_edge(ch, EDGE_FALL, start + width);
      recent_rise[ch] = start;
      recent_pw[ch]   = width[15:0];
   endtask

   // drain all results, then let the pipeline empty of no-result edges
   task automatic settle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // back-to-back writes of the whole map plus one write to an unmapped index
   task automatic write_regs(input logic [CSR_BITS-1:0] db, input logic [CSR_BITS-1:0] tol,
                             input logic [CSR_BITS-1:0] snap,
                             input logic [CSR_BITS-1:0] notify);
      settle();
      csr_we    <= 1'b1;
      csr_index <= CSR_DEADBAND;
      csr_wdata <= db;
      @(posedge clock);
      csr_index <= CSR_SNAP_TOL;
      csr_wdata <= tol;
      @(posedge clock);
      csr_index <= CSR_SNAP_MASK;
      csr_wdata <= snap;
      @(posedge clock);
      csr_index <= CSR_NOTIFY_MASK;
      csr_wdata <= notify;
      @(posedge clock);
      csr_index <= csr_index_type'(CSR_NOTIFY_MASK + $urandom_range(1, 4));
      csr_wdata <= CSR_BITS'($urandom);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // mostly servo-like widths, with aims at snap points and the deadband edge
   function automatic logic [STAMP_BITS-1:0] pick_width(input logic [CHAN_BITS-1:0] ch);
      logic [STAMP_BITS-1:0] w;
      int                    anchor;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: w = $urandom_range(950, 2050);
         4: begin
            case ($urandom_range(0, 2))
               0: anchor = PW_LOW;
               1: anchor = PW_MID;
               default: anchor = PW_HIGH;
            endcase
            w = anchor + $urandom_range(0, 80) - 40;
         end
         5: w = int'(recent_pw[ch]) + $urandom_range(0, 40) - 20;
         6: w = STAMP_BITS'(recent_pw[ch]);
         7: w = $urandom_range(0, 999);
         8: w = $urandom_range(2001, 70000);
         default: w = $urandom;
      endcase
      return w;
   endfunction

   task automatic random_phase(input int count);
      int                    sent_here;
      logic [CHAN_BITS-1:0]  ch;
      logic [STAMP_BITS-1:0] w;
      sent_here = 0;
      while (sent_here < count) begin
         ch = CHAN_BITS'($urandom_range(0, 7));
         case ($urandom_range(0, 9))
            0: begin
               // noise: a lone edge at any time
               send_edge(ch, 1'($urandom_range(0, 1)), $urandom);
               sent_here++;
            end
            1: begin
               // second falling edge on the same start
               w = pick_width(ch);
               send_edge(ch, EDGE_FALL, recent_rise[ch] + w);
               recent_pw[ch] = w[15:0];
               sent_here++;
            end
            2: begin
               // broken pair: rise, then stray rise before the fall
               send_edge(ch, EDGE_RISE, $urandom);
               send_pulse(ch, $urandom, pick_width(ch));
               sent_here += 3;
            end
            default: begin
               w = pick_width(ch);
               send_pulse(ch, $urandom, w);
               sent_here += 2;
            end
         endcase
         // now and then hold off until every result is back
         if ($urandom_range(0, 149) == 0)
            settle();
      end
   endtask

   initial begin
      int per_phase;
      reset           <= 1'b1;
      csr_we          <= 1'b0;
      csr_index       <= CSR_DEADBAND;
      csr_wdata       <= '0;
      req_bus.valid   <= 1'b0;
      req_bus.channel <= '0;
      req_bus.mode    <= EDGE_RISE;
      req_bus.time_us <= '0;
      foreach (recent_pw[c]) begin
         recent_pw[c]   = PW_MID;
         recent_rise[c] = '0;
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset settings: notify is off, but state still moves
      send_edge(3'd0, EDGE_FALL, 32'd5);          // fall with no rise seen
      send_pulse(3'd4, 32'd0, 32'd1010);          // snaps to 1000 on a default snap channel

      // narrowest windows, every channel reports
      write_regs(8'd0, 8'd0, 8'h00, 8'hFF);
      send_pulse(3'd1, 32'hFFFF_FF00, 32'd1756);  // start before wrap, end after it
      send_pulse(3'd2, 32'd0, 32'hFFFF_FFFF);     // saturates, clamps to 2000
      send_edge(3'd2, EDGE_FALL, 32'hFFFF_FFFF);  // steady out-of-range keeps reporting
      send_pulse(3'd3, 32'd100, 32'd0);           // zero width clamps to 1000
      send_pulse(3'd7, 32'd1000, 32'd2000);       // top point exactly
      send_pulse(3'd5, 32'h8000_0000, 32'd1500);  // mid point

      // widest windows, overlapping snap ranges
      write_regs(8'd255, 8'd255, 8'hFF, 8'hFF);
      send_pulse(3'd6, 32'hAAAA_AAAA, 32'd1250);  // both 1000 and 1500 match, 1000 wins
      send_pulse(3'd0, 32'h0000_1234, 32'd1400);
      send_edge(3'd0, EDGE_FALL, 32'h0000_1234 + 32'd1400);
      send_pulse(3'd1, 32'h5555_5555, 32'd1600);  // inside deadband of the old width

      per_phase = RANDOM_ITEMS / PHASES;
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: write_regs(8'd10, 8'd20, 8'h50, 8'hFF);
            1: write_regs(8'd0, 8'd0, 8'h00, 8'hFF);
            2: write_regs(8'd255, 8'd255, 8'hFF, 8'hFF);
            3: write_regs(CSR_BITS'($urandom_range(0, 40)), CSR_BITS'($urandom_range(0, 60)),
                          CSR_BITS'($urandom), CSR_BITS'($urandom | 8'h0F));
            4: write_regs(CSR_BITS'($urandom), CSR_BITS'($urandom), CSR_BITS'($urandom),
                          CSR_BITS'($urandom));
            default: write_regs(CSR_BITS'($urandom_range(0, 20)), CSR_BITS'($urandom),
                                CSR_BITS'($urandom), 8'hFF);
         endcase
         // one whole phase with no idling on either side
         quiet = (p == 3);
         random_phase(per_phase);
      end
      quiet = 1'b0;

      settle();
      $display("sent %0d edge beats over %0d register settings, checked %0d result beats",
               beats_sent, PHASES + 3, results_seen);
      $display("covered wrapping stamps, saturation, snapping, deadband and backpressure");
      if (failures == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
